[design/sblr_pkg.sv]
// ----------------------------------------------------------------------------
// sblr_pkg: shared types and constants
// Command word passed from the byte front end to the output sequencer.
// ----------------------------------------------------------------------------
package sblr_pkg;

  localparam logic [31:0] CrcPoly = 32'hEDB88320;

  localparam logic [1:0] OUT_BYTE   = 2'd0;
  localparam logic [1:0] OUT_WRITE  = 2'd1;
  localparam logic [1:0] OUT_BRANCH = 2'd2;

  localparam logic [2:0] REG_VERSION = 3'd0;
  localparam logic [2:0] REG_LOW     = 3'd1;
  localparam logic [2:0] REG_HIGH    = 3'd2;
  localparam logic [2:0] REG_ACK     = 3'd3;
  localparam logic [2:0] REG_NAK     = 3'd4;
  localparam logic [2:0] REG_MARKER  = 3'd5;
  localparam logic [2:0] REG_ENTRY   = 3'd6;

  typedef enum logic [1:0] {
    CMD_REPLY  = 2'd0,
    CMD_WRITE  = 2'd1,
    CMD_FINISH = 2'd2
  } cmd_op_t;

  // A reply sends one word as four bytes. A write emits one memory write.
  // A finish sends a word and then a branch.
  typedef struct packed {
    cmd_op_t     op;
    logic [31:0] word;
    logic [31:0] address;
  } cmd_t;

  typedef enum logic [4:0] {
    PH_IDLE    = 5'b00001,
    PH_HEADER  = 5'b00010,
    PH_PAYLOAD = 5'b00100,
    PH_MARKER  = 5'b01000,
    PH_HALTED  = 5'b10000
  } phase_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

[design/serial_boot_loader_receiver.sv]
// ----------------------------------------------------------------------------
// serial_boot_loader_receiver: boot image receiver
// Input words carry a start mark or one received byte; output words carry
// bytes to transmit, memory writes and a final branch. The front end takes
// one input word per cycle whenever the two-entry command queue has room,
// and the sequencer drains a command at one result per cycle while the
// result receiver is ready: four results for a word reply, five for the
// final reply plus branch, one for a write. The first result passes the
// command queue and then the output register. With a ready receiver the
// payload runs one byte per cycle; elsewhere the replies can hold input.
// Reset clears the session to idle, sets the configuration to defaults and
// empties the queue. When the result receiver stalls, the output register
// holds, the queue fills, and in_ready falls once it is full.
// Configuration writes take effect at the next clock edge and should be
// made while the block is idle.
// ----------------------------------------------------------------------------
module serial_boot_loader_receiver
  import sblr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        kind,
  input  logic [7:0]  rx_byte,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [7:0]  tx_byte,
  output logic [31:0] mem_address,
  output logic [31:0] mem_word,
  output logic        last
);

  logic [31:0] expected_version;
  logic [31:0] lowest_load_address;
  logic [31:0] highest_end_address;
  logic [31:0] ack_word;
  logic [31:0] nak_word;
  logic [31:0] end_marker_word;
  logic [7:0]  entry_offset;

  logic q_push;
  cmd_t q_in;
  logic q_not_full;
  logic q_not_empty;
  cmd_t q_head;
  logic q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_version <= 32'd2;
      lowest_load_address <= 32'd32768;
      highest_end_address <= 32'd134217728;
      ack_word <= 32'd1;
      nak_word <= 32'd2;
      end_marker_word <= 32'd3;
      entry_offset <= 8'd8;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_VERSION: expected_version <= cfg_data;
        REG_LOW:     lowest_load_address <= cfg_data;
        REG_HIGH:    highest_end_address <= cfg_data;
        REG_ACK:     ack_word <= cfg_data;
        REG_NAK:     nak_word <= cfg_data;
        REG_MARKER:  end_marker_word <= cfg_data;
        REG_ENTRY:   entry_offset <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  sblr_front u_front (
    .clk, .rst, .kind, .rx_byte, .in_valid, .in_ready,
    .expected_version, .lowest_load_address, .highest_end_address,
    .ack_word, .nak_word, .end_marker_word, .entry_offset,
    .cmd_valid(q_push), .cmd(q_in), .cmd_ready(q_not_full)
  );

  sblr_queue u_queue (
    .clk, .rst, .push(q_push), .push_cmd(q_in), .not_full(q_not_full),
    .not_empty(q_not_empty), .head(q_head), .pop(q_pop)
  );

  sblr_back u_back (
    .clk, .rst, .cmd_valid(q_not_empty), .cmd(q_head), .cmd_pop(q_pop),
    .out_valid, .out_ready, .out_kind, .tx_byte, .mem_address, .mem_word, .last
  );

endmodule

[design/sblr_front.sv]
// ----------------------------------------------------------------------------
// sblr_front: byte front end
// Assembles words, checks the header, tracks the CRC and issues commands.
// ----------------------------------------------------------------------------
module sblr_front
  import sblr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        kind,
  input  logic [7:0]  rx_byte,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] expected_version,
  input  logic [31:0] lowest_load_address,
  input  logic [31:0] highest_end_address,
  input  logic [31:0] ack_word,
  input  logic [31:0] nak_word,
  input  logic [31:0] end_marker_word,
  input  logic [7:0]  entry_offset,
  output logic        cmd_valid,
  output cmd_t        cmd,
  input  logic        cmd_ready
);

  phase_t      phase;
  logic [1:0]  byte_in_word;
  logic [23:0] word_assembly;
  logic [1:0]  header_word_index;
  logic        version_matched;
  logic [31:0] load_address;
  logic [29:0] words_remaining;
  logic [31:0] expected_checksum;
  logic [31:0] running_crc;
  logic [31:0] write_pointer;

  logic        take;
  logic [31:0] w;
  logic [31:0] crc_next;
  logic [32:0] end_sum;
  logic        hdr_ok;
  logic        word_done;

  // An item is taken only when the queue has room for whatever it may issue.
  assign in_ready  = cmd_ready;
  assign take      = in_valid && in_ready;
  assign w         = {rx_byte, word_assembly};
  assign crc_next  = crc_byte(running_crc, rx_byte);
  assign end_sum   = {1'b0, load_address} + {1'b0, w};
  assign hdr_ok    = (load_address >= lowest_load_address) &&
                     (end_sum <= {1'b0, highest_end_address}) && (w[1:0] == 2'b00);
  assign word_done = (byte_in_word == 2'd3);

  always_comb begin
    cmd_valid = 1'b0;
    cmd.op = CMD_REPLY;
    cmd.word = ack_word;
    cmd.address = load_address + {24'd0, entry_offset};
    if (take) begin
      if (!kind) begin
        cmd_valid = 1'b1;
      end else if (word_done) begin
        unique case (phase)
          PH_HEADER: begin
            if (header_word_index == 2'd3) begin
              cmd_valid = 1'b1;
              cmd.word = version_matched ? ack_word : nak_word;
            end
          end
          PH_PAYLOAD: begin
            cmd_valid = 1'b1;
            cmd.op = CMD_WRITE;
            cmd.word = w;
            cmd.address = write_pointer;
          end
          PH_MARKER: begin
            cmd_valid = 1'b1;
            if (w != end_marker_word || ~running_crc != expected_checksum) begin
              cmd.word = nak_word;
            end else begin
              cmd.op = CMD_FINISH;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      byte_in_word <= '0;
      word_assembly <= '0;
      header_word_index <= '0;
      version_matched <= 1'b0;
      load_address <= '0;
      words_remaining <= '0;
      expected_checksum <= '0;
      running_crc <= '1;
      write_pointer <= '0;
    end else if (take) begin
      if (!kind) begin
        phase <= PH_HEADER;
        byte_in_word <= '0;
        word_assembly <= '0;
        header_word_index <= '0;
        version_matched <= 1'b0;
        load_address <= '0;
        words_remaining <= '0;
        expected_checksum <= '0;
        running_crc <= '1;
        write_pointer <= '0;
      end else if (phase == PH_HEADER || phase == PH_PAYLOAD || phase == PH_MARKER) begin
        if (phase == PH_PAYLOAD) begin
          running_crc <= crc_next;
        end
        if (!word_done) begin
          unique case (byte_in_word)
            2'd0: word_assembly[7:0] <= rx_byte;
            2'd1: word_assembly[15:8] <= rx_byte;
            default: word_assembly[23:16] <= rx_byte;
          endcase
          byte_in_word <= byte_in_word + 2'd1;
        end else begin
          word_assembly <= '0;
          byte_in_word <= '0;
          unique case (phase)
            PH_HEADER: begin
              header_word_index <= header_word_index + 2'd1;
              unique case (header_word_index)
                2'd0: version_matched <= (w == expected_version);
                2'd1: load_address <= w;
                2'd2: begin
                  if (!hdr_ok) begin
                    version_matched <= 1'b0;
                  end
                  words_remaining <= w[31:2];
                end
                default: begin
                  expected_checksum <= w;
                  if (version_matched) begin
                    write_pointer <= load_address;
                    running_crc <= '1;
                    phase <= (words_remaining != '0) ? PH_PAYLOAD : PH_MARKER;
                  end else begin
                    phase <= PH_HALTED;
                  end
                end
              endcase
            end
            PH_PAYLOAD: begin
              write_pointer <= write_pointer + 32'd4;
              words_remaining <= words_remaining - 30'd1;
              if (words_remaining == 30'd1) begin
                phase <= PH_MARKER;
              end
            end
            default: phase <= PH_HALTED;
          endcase
        end
      end
    end
  end

endmodule

[design/sblr_queue.sv]
// ----------------------------------------------------------------------------
// sblr_queue: command queue
// Two-entry FIFO between the front end and the output sequencer.
// ----------------------------------------------------------------------------
module sblr_queue
  import sblr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic not_full,
  output logic not_empty,
  output cmd_t head,
  input  logic pop
);

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign not_full  = (count != 2'd2);
  assign not_empty = (count != 2'd0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

[design/sblr_back.sv]
// ----------------------------------------------------------------------------
// sblr_back: output sequencer
// Expands one command into its result words through an output register.
// ----------------------------------------------------------------------------
module sblr_back
  import sblr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  input  cmd_t        cmd,
  output logic        cmd_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [7:0]  tx_byte,
  output logic [31:0] mem_address,
  output logic [31:0] mem_word,
  output logic        last
);

  // step counts results of the current command: bytes 0..3, then a branch.
  logic [2:0] step;
  logic       load;
  logic       done;

  assign load = !out_valid || out_ready;
  assign done = (cmd.op == CMD_WRITE) || (cmd.op == CMD_REPLY && step == 3'd3) ||
                (cmd.op == CMD_FINISH && step == 3'd4);
  assign cmd_pop = cmd_valid && load && done;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      step <= '0;
    end else if (load) begin
      out_valid <= cmd_valid;
      if (cmd_valid) begin
        step <= done ? 3'd0 : step + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && cmd_valid) begin
      last <= done;
      if (cmd.op == CMD_WRITE) begin
        out_kind <= OUT_WRITE;
        tx_byte <= '0;
        mem_address <= cmd.address;
        mem_word <= cmd.word;
      end else if (step == 3'd4) begin
        out_kind <= OUT_BRANCH;
        tx_byte <= '0;
        mem_address <= cmd.address;
        mem_word <= '0;
      end else begin
        out_kind <= OUT_BYTE;
        tx_byte <= cmd.word[{step[1:0], 3'b000} +: 8];
        mem_address <= '0;
        mem_word <= '0;
      end
    end
  end

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// Boot loader receiver testbench
// Sends boot sessions as byte streams: well-formed images with random
// content, broken headers, bad markers and checksums, stray bytes and
// restarts. The checker follows the protocol word by word and compares every
// output word with its prediction.
// ----------------------------------------------------------------------------
module testbench;
  import sblr_pkg::*;

  typedef struct packed {
    logic [1:0]  okind;
    logic [7:0]  tx;
    logic [31:0] addr;
    logic [31:0] data;
    logic        lst;
  } result_t;

  // Predicts the block's output words and checks them in order.
  class boot_scoreboard;
    logic [31:0] cfg [7];
    phase_t      phase;
    logic [1:0]  byte_pos;
    logic [23:0] assembly;
    logic [1:0]  hdr_idx;
    logic        hdr_ok;
    logic [31:0] load_addr;
    logic [29:0] words_left;
    logic [31:0] checksum;
    logic [31:0] crc;
    logic [31:0] wr_ptr;
    result_t     pending[$];
    int          errors;
    int          checked;

    function void clear_session();
      byte_pos = 0; assembly = 0; hdr_idx = 0; hdr_ok = 0; load_addr = 0;
      words_left = 0; checksum = 0; crc = '1; wr_ptr = 0;
    endfunction

    function void reset();
      cfg[REG_VERSION] = 2; cfg[REG_LOW] = 32'h8000; cfg[REG_HIGH] = 32'h800_0000;
      cfg[REG_ACK] = 1; cfg[REG_NAK] = 2; cfg[REG_MARKER] = 3; cfg[REG_ENTRY] = 8;
      phase = PH_IDLE;
      clear_session();
    endfunction

    function void push_word(logic [31:0] w);
      result_t r;
      for (int i = 0; i < 4; i++) begin
        r = '{OUT_BYTE, w[8*i +: 8], 32'd0, 32'd0, 1'b0};
        pending.push_back(r);
      end
    endfunction

    function void mark_last(int start_size);
      result_t r;
      if (pending.size() > start_size) begin
        r = pending[$];
        r.lst = 1;
        pending[pending.size()-1] = r;
      end
    endfunction

    function logic [31:0] next_crc(logic [31:0] c, logic [7:0] b);
      logic [31:0] x;
      x = c ^ {24'd0, b};
      for (int i = 0; i < 8; i++) x = x[0] ? ((x >> 1) ^ 32'hEDB88320) : (x >> 1);
      return x;
    endfunction

    function void note_input(logic k, logic [7:0] b);
      int          n0;
      logic [31:0] w;
      logic [32:0] span;
      result_t     r;
      n0 = pending.size();
      if (!k) begin
        clear_session();
        phase = PH_HEADER;
        push_word(cfg[REG_ACK]);
        mark_last(n0);
        return;
      end
      if (phase == PH_IDLE || phase == PH_HALTED) return;
      if (phase == PH_PAYLOAD) crc = next_crc(crc, b);
      if (byte_pos != 3) begin
        assembly[8*byte_pos +: 8] = b;
        byte_pos++;
        return;
      end
      w = {b, assembly};
      assembly = 0;
      byte_pos = 0;
      if (phase == PH_HEADER) begin
        case (hdr_idx)
          0: hdr_ok = (w == cfg[REG_VERSION]);
          1: load_addr = w;
          2: begin
            span = {1'b0, load_addr} + {1'b0, w};
            if (load_addr < cfg[REG_LOW] || span > {1'b0, cfg[REG_HIGH]} || w[1:0] != 0)
              hdr_ok = 0;
            words_left = w[31:2];
          end
          default: begin
            checksum = w;
            if (hdr_ok) begin
              push_word(cfg[REG_ACK]);
              wr_ptr = load_addr;
              crc = '1;
              phase = (words_left != 0) ? PH_PAYLOAD : PH_MARKER;
            end else begin
              push_word(cfg[REG_NAK]);
              phase = PH_HALTED;
            end
          end
        endcase
        hdr_idx++;
      end else if (phase == PH_PAYLOAD) begin
        r = '{OUT_WRITE, 8'd0, wr_ptr, w, 1'b0};
        pending.push_back(r);
        wr_ptr += 4;
        words_left--;
        if (words_left == 0) phase = PH_MARKER;
      end else begin
        if (w != cfg[REG_MARKER] || ~crc != checksum) begin
          push_word(cfg[REG_NAK]);
        end else begin
          push_word(cfg[REG_ACK]);
          r = '{OUT_BRANCH, 8'd0, load_addr + {24'd0, cfg[REG_ENTRY][7:0]}, 32'd0, 1'b0};
          pending.push_back(r);
        end
        phase = PH_HALTED;
      end
      mark_last(n0);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected word kind=%0d tx=%h addr=%h data=%h last=%0d", $time,
                 got.okind, got.tx, got.addr, got.data, got.lst);
        errors++;
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.okind != want.okind) begin
        $display("%0t: out_kind expected %0d actual %0d", $time, want.okind, got.okind);
        errors++;
      end
      if (got.tx != want.tx) begin
        $display("%0t: tx_byte expected %h actual %h", $time, want.tx, got.tx);
        errors++;
      end
      if (got.addr != want.addr) begin
        $display("%0t: mem_address expected %h actual %h", $time, want.addr, got.addr);
        errors++;
      end
      if (got.data != want.data) begin
        $display("%0t: mem_word expected %h actual %h", $time, want.data, got.data);
        errors++;
      end
      if (got.lst != want.lst) begin
        $display("%0t: last expected %0d actual %0d", $time, want.lst, got.lst);
        errors++;
      end
    endfunction
  endclass

  logic        clk, rst;
  logic        in_valid, in_ready, kind;
  logic [7:0]  rx_byte;
  logic        cfg_write;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        out_valid, out_ready;
  logic [1:0]  out_kind;
  logic [7:0]  tx_byte;
  logic [31:0] mem_address, mem_word;
  logic        last;

  serial_boot_loader_receiver u_dut (.*);

  boot_scoreboard sb;
  int send_idle_pct, recv_idle_pct;
  int words_sent, idle_cycles, sessions;
  logic [7:0] image[$];

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("%0t: watchdog expired", $time);
      $display("testbench failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready)
        sb.check_result('{out_kind, tx_byte, mem_address, mem_word, last});
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // The valid line stays high after an accepted word only until the next
  // word or an idle cycle drops it, so back-to-back words need no gap.
  task automatic send_word(input logic k, input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    kind <= k;
    rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(k, b);
    words_sent++;
  endtask

  task automatic send_u32(input logic [31:0] w);
    for (int i = 0; i < 4; i++) send_word(1, w[8*i +: 8]);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] v);
    cfg_write <= 1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_write <= 0;
    sb.cfg[idx] = (idx == REG_ENTRY) ? {24'd0, v[7:0]} : v;
    @(posedge clk);
  endtask

  // One session: start, header, payload, marker. Flaws select what breaks.
  task automatic session(input int nwords, input logic [31:0] addr, input int flaw);
    logic [31:0] c, cnt, w;
    c = '1;
    image.delete();
    for (int i = 0; i < 4 * nwords; i++) begin
      image.push_back($urandom_range(255));
      c = sb.next_crc(c, image[$]);
    end
    cnt = 4 * nwords;
    send_word(0, $urandom_range(255));
    send_u32(flaw == 1 ? sb.cfg[REG_VERSION] ^ (1 << $urandom_range(31))
                       : sb.cfg[REG_VERSION]);
    send_u32(addr);
    send_u32(flaw == 2 ? cnt | 32'd2 : cnt);
    send_u32(flaw == 3 ? c : ~c);
    if (flaw == 6) begin
      send_word(0, 0);
      return;
    end
    for (int i = 0; i < image.size(); i++) send_word(1, image[i]);
    w = sb.cfg[REG_MARKER];
    send_u32(flaw == 4 ? ~w : w);
    // bytes after the end are ignored
    if (flaw == 5) repeat (3) send_word(1, $urandom_range(255));
    sessions++;
  endtask

  task automatic random_phase(input int n);
    int flaw, nw;
    logic [31:0] a;
    while (words_sent < n) begin
      flaw = ($urandom_range(9) < 7) ? 0 : $urandom_range(6);
      nw = ($urandom_range(9) == 0) ? $urandom_range(12) : $urandom_range(4);
      a = sb.cfg[REG_LOW] + 4 * $urandom_range(64);
      if ($urandom_range(9) == 0) begin
        repeat ($urandom_range(1, 9)) send_word($urandom_range(1), $urandom_range(255));
      end else begin
        session(nw, a, flaw);
      end
    end
  endtask

  initial begin
    sb = new();
    sb.reset();
    sb.errors = 0; sb.checked = 0;
    words_sent = 0; sessions = 0; idle_cycles = 0;
    rst = 1; in_valid = 0; kind = 0; rx_byte = 0;
    cfg_write = 0; cfg_index = REG_VERSION; cfg_data = 0; out_ready = 0;
    send_idle_pct = 0; recv_idle_pct = 0;
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: ignored bytes while idle, edge bytes, defaults.
    send_word(1, 8'hff);
    send_word(1, 8'h00);
    session(1, 32'h8000, 0);
    session(0, 32'h8000, 0);
    session(0, 32'h0000_7ffc, 0);           // address below window
    session(0, 32'h07ff_fffc, 2);           // count not a multiple of four
    drain();

    // Extreme settings: a sum past the high limit fails, the full window passes.
    write_reg(REG_VERSION, 32'hffff_ffff);
    write_reg(REG_LOW, 32'h0);
    write_reg(REG_HIGH, 32'hffff_ffff);
    write_reg(REG_ACK, 32'ha5c3_00ff);
    write_reg(REG_NAK, 32'h0);
    write_reg(REG_MARKER, 32'hffff_ffff);
    write_reg(REG_ENTRY, 32'hff);
    session(1, 32'hffff_fffc, 0);            // end lies one past the high limit
    session(2, 32'hffff_fffc, 0);            // 33-bit sum exceeds the limit
    session(1, 32'h0, 3);
    session(1, 32'h0, 4);
    session(1, 32'h0, 1);
    session(2, 32'h100, 6);                  // restart after the header, before the payload
    drain();
    write_reg(REG_VERSION, 32'h0);
    write_reg(REG_LOW, 32'hffff_fff0);
    write_reg(REG_MARKER, 32'h0);
    write_reg(REG_ENTRY, 32'h00);
    session(2, 32'hffff_fff0, 0);
    drain();

    write_reg(REG_VERSION, $urandom);
    write_reg(REG_LOW, 32'h1000);
    write_reg(REG_HIGH, 32'h0010_0000);
    write_reg(REG_ACK, $urandom);
    write_reg(REG_NAK, $urandom);
    write_reg(REG_MARKER, $urandom);
    write_reg(REG_ENTRY, $urandom_range(255));

    send_idle_pct = 18; recv_idle_pct = 88;
    random_phase(words_sent + 10);
    drain();
    send_idle_pct = 88; recv_idle_pct = 18;
    random_phase(words_sent + 10);
    drain();
    // Back to the default settings; the session state is left as it is.
    write_reg(REG_VERSION, 32'd2);
    write_reg(REG_LOW, 32'h8000);
    write_reg(REG_HIGH, 32'h800_0000);
    write_reg(REG_ACK, 32'd1);
    write_reg(REG_NAK, 32'd2);
    write_reg(REG_MARKER, 32'd3);
    write_reg(REG_ENTRY, 32'd8);
    send_idle_pct = 0; recv_idle_pct = 0;
    random_phase(words_sent + 10);

    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Sent %0d input words over %0d sessions; checked %0d output words.",
             words_sent, sessions, sb.checked);
    $display("Covered good images, header and trailer failures, restarts and stray bytes.");
    if (sb.errors == 0 && sb.pending.size() == 0) $display("testbench passed");
    else $display("testbench failed");
    $finish;
  end
endmodule

[serial_boot_loader_receiver.f]
design/sblr_pkg.sv
design/sblr_front.sv
design/sblr_queue.sv
design/sblr_back.sv
design/serial_boot_loader_receiver.sv
tb/testbench.sv
